>>> hdl/tce_pkg.sv
// Shared types and constants for the countdown timer with click button and encoder.
// Used by tce_button, tce_time and countdown_timer_click_encoder.
`default_nettype none

package tce_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned MIN_W  = 7;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned PCNT_W = 4;

  // Register indexes, byte address is four times the index.
  localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [2:0] REG_MULTI     = 3'd1;
  localparam logic [2:0] REG_START_MIN = 3'd2;
  localparam logic [2:0] REG_START_SEC = 3'd3;
  localparam logic [2:0] REG_MAX_MIN   = 3'd4;
  localparam logic [2:0] REG_PERIOD    = 3'd5;

  localparam logic [9:0]       RST_DEBOUNCE  = 10'd50;
  localparam logic [10:0]      RST_MULTI     = 11'd500;
  localparam logic [5:0]       RST_START_MIN = 6'd0;
  localparam logic [5:0]       RST_START_SEC = 6'd10;
  localparam logic [MIN_W-1:0] RST_MAX_MIN   = 7'd60;
  localparam logic [MS_W-1:0]  RST_PERIOD    = 16'd1000;

  localparam logic [MS_W-1:0]   MS_SAT    = 16'hFFFF;
  localparam logic [PCNT_W-1:0] PRESS_MAX = 4'd15;
  localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_SKIP  = 6'd40;

  typedef struct packed {
    logic [9:0]       debounce;
    logic [10:0]      multi;
    logic [5:0]       start_min;
    logic [5:0]       start_sec;
    logic [MIN_W-1:0] max_min;
    logic [MS_W-1:0]  period;
  } cfg_t;

  typedef struct packed {
    logic       min_we;
    logic       sec_we;
    logic [5:0] value;
  } ld_t;

  typedef struct packed {
    logic one_click;
    logic two_click;
  } click_t;

  typedef struct packed {
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic             running;
    logic             paused;
    logic             alarm;
    logic             tick_pulse;
  } res_t;

  function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v, input logic step);
    sat_inc = (step && v != MS_SAT) ? v + 1'b1 : v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tce_button.sv
// Button debounce, press counting and click classification.
// Depends on tce_pkg; state advances only when en is high.
`default_nettype none

module tce_button (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          button_level,
  input  wire logic          ms_tick,
  input  wire tce_pkg::cfg_t cfg,
  output tce_pkg::click_t    click
);
  import tce_pkg::*;

  logic              last_raw_r, last_raw_nxt;
  logic              stable_r, stable_nxt;
  logic [MS_W-1:0]   steady_r, steady_nxt;
  logic [MS_W-1:0]   since_r, since_nxt;
  logic [PCNT_W-1:0] press_r, press_nxt;

  logic [MS_W-1:0]   steady_inc;
  logic [MS_W-1:0]   since_inc;
  logic [PCNT_W-1:0] press_c;
  logic              fire;
  logic              hit;

  always_comb begin
    steady_inc = sat_inc(steady_r, ms_tick);
    since_inc  = sat_inc(since_r, ms_tick);
    steady_nxt = (button_level != last_raw_r) ? '0 : steady_inc;
    fire       = (steady_nxt > {6'd0, cfg.debounce}) && (button_level != stable_r);
    stable_nxt = fire ? button_level : stable_r;
    press_c    = press_r;
    since_nxt  = since_inc;
    if (fire && !button_level) begin
      if (since_inc > {5'd0, cfg.multi}) begin
        press_c = PCNT_W'(1);
      end else if (press_r != PRESS_MAX) begin
        press_c = press_r + 1'b1;
      end
      since_nxt = '0;
    end
    // The press window closes once no new press came within multi_click_ms.
    hit             = (press_c != '0) && (since_nxt >= {5'd0, cfg.multi});
    click.one_click = hit && (press_c == PCNT_W'(1));
    click.two_click = hit && (press_c != PCNT_W'(1));
    press_nxt       = hit ? '0 : press_c;
    last_raw_nxt    = button_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      stable_r   <= 1'b1;
      steady_r   <= '0;
      since_r    <= '0;
      press_r    <= '0;
    end else if (en) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      steady_r   <= steady_nxt;
      since_r    <= since_nxt;
      press_r    <= press_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tce_time.sv
// Time keeping: click actions, encoder set-time stepping, countdown and alarm latch.
// Depends on tce_pkg; state advances when en is high, start loads come from the config port.
`default_nettype none

module tce_time (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            enc_a,
  input  wire logic            enc_b,
  input  wire logic            ms_tick,
  input  wire tce_pkg::click_t click,
  input  wire tce_pkg::cfg_t   cfg,
  input  wire tce_pkg::ld_t    ld,
  output tce_pkg::res_t        res
);
  import tce_pkg::*;

  logic [MIN_W-1:0] set_min_r, set_min_nxt, cur_min_r, cur_min_nxt, sav_min_r, sav_min_nxt;
  logic [SEC_W-1:0] set_sec_r, set_sec_nxt, cur_sec_r, cur_sec_nxt, sav_sec_r, sav_sec_nxt;
  logic             stopped_r, stopped_nxt, fresh_r, fresh_nxt, pause_r, pause_nxt;
  logic             savep_r, savep_nxt, prev_a_r, alarm_r, alarm_nxt;
  logic [MS_W-1:0]  since_dec_r, since_dec_nxt;

  logic [MIN_W-1:0] set_min_c, cur_min_c;
  logic [SEC_W-1:0] set_sec_c, cur_sec_c;
  logic             alarm_c, fall, step_up, step_dn, tick;
  logic [MS_W-1:0]  since_inc;

  always_comb begin
    since_inc   = sat_inc(since_dec_r, ms_tick);
    stopped_nxt = stopped_r;
    fresh_nxt   = fresh_r;
    pause_nxt   = pause_r;
    savep_nxt   = savep_r;
    sav_min_nxt = sav_min_r;
    sav_sec_nxt = sav_sec_r;
    set_min_c   = set_min_r;
    set_sec_c   = set_sec_r;
    cur_min_c   = cur_min_r;
    cur_sec_c   = cur_sec_r;
    alarm_c     = alarm_r;
    if (click.one_click) begin
      stopped_nxt = !stopped_r;
      if (fresh_r) begin
        fresh_nxt = 1'b0;
      end else begin
        pause_nxt = !pause_r;
      end
      if (savep_r) begin
        sav_min_nxt = set_min_r;
        sav_sec_nxt = set_sec_r;
        savep_nxt   = 1'b0;
      end
      set_min_c = cur_min_r;
      set_sec_c = cur_sec_r;
    end else if (click.two_click) begin
      stopped_nxt = 1'b1;
      fresh_nxt   = 1'b1;
      pause_nxt   = 1'b0;
      savep_nxt   = 1'b1;
      set_min_c   = sav_min_r;
      set_sec_c   = sav_sec_r;
      cur_min_c   = sav_min_r;
      cur_sec_c   = sav_sec_r;
      alarm_c     = 1'b0;
    end

    fall    = prev_a_r && !enc_a;
    step_up = fall && !enc_b && !pause_nxt;
    step_dn = fall && enc_b && !pause_nxt;

    set_min_nxt   = set_min_c;
    set_sec_nxt   = set_sec_c;
    cur_min_nxt   = cur_min_c;
    cur_sec_nxt   = cur_sec_c;
    since_dec_nxt = since_inc;
    tick          = 1'b0;
    if (stopped_nxt) begin
      if (step_up) begin
        // At or past the maximum minutes the set time wraps to 00:01; seconds from 59 up carry.
        if (set_min_c >= cfg.max_min) begin
          set_min_nxt = '0;
          set_sec_nxt = SEC_W'(1);
        end else if (set_sec_c >= SEC_LAST) begin
          set_min_nxt = set_min_c + 1'b1;
          set_sec_nxt = '0;
        end else begin
          set_sec_nxt = set_sec_c + 1'b1;
        end
      end else if (step_dn) begin
        if (set_min_c == '0 && set_sec_c <= SEC_W'(1)) begin
          set_min_nxt = cfg.max_min;
          set_sec_nxt = '0;
        end else if (set_sec_c == '0) begin
          set_min_nxt = set_min_c - 1'b1;
          set_sec_nxt = SEC_LAST;
        end else if (set_sec_c > SEC_LAST + SEC_W'(1)) begin
          set_sec_nxt = set_sec_c - SEC_SKIP - SEC_W'(1);
        end else begin
          set_sec_nxt = set_sec_c - 1'b1;
        end
      end
      cur_min_nxt = set_min_nxt;
      cur_sec_nxt = set_sec_nxt;
    end else if (since_inc > cfg.period && (cur_min_c != '0 || cur_sec_c != '0)) begin
      tick = 1'b1;
      if (cur_sec_c == '0) begin
        cur_sec_nxt = SEC_LAST;
        cur_min_nxt = cur_min_c - 1'b1;
      end else begin
        cur_sec_nxt = cur_sec_c - 1'b1;
      end
      since_dec_nxt = '0;
    end

    alarm_nxt      = alarm_c || (cur_min_nxt == '0 && cur_sec_nxt == '0);
    res.minutes    = cur_min_nxt;
    res.seconds    = cur_sec_nxt;
    res.running    = !stopped_nxt;
    res.paused     = pause_nxt;
    res.alarm      = alarm_nxt;
    res.tick_pulse = tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_min_r   <= {1'b0, RST_START_MIN};
      set_sec_r   <= RST_START_SEC;
      cur_min_r   <= {1'b0, RST_START_MIN};
      cur_sec_r   <= RST_START_SEC;
      sav_min_r   <= '0;
      sav_sec_r   <= '0;
      stopped_r   <= 1'b1;
      fresh_r     <= 1'b1;
      pause_r     <= 1'b0;
      savep_r     <= 1'b1;
      since_dec_r <= '0;
      prev_a_r    <= 1'b0;
      alarm_r     <= 1'b0;
    end else if (ld.min_we || ld.sec_we) begin
      if (ld.min_we) begin
        set_min_r <= {1'b0, ld.value};
        cur_min_r <= {1'b0, ld.value};
      end
      if (ld.sec_we) begin
        set_sec_r <= ld.value;
        cur_sec_r <= ld.value;
      end
    end else if (en) begin
      set_min_r   <= set_min_nxt;
      set_sec_r   <= set_sec_nxt;
      cur_min_r   <= cur_min_nxt;
      cur_sec_r   <= cur_sec_nxt;
      sav_min_r   <= sav_min_nxt;
      sav_sec_r   <= sav_sec_nxt;
      stopped_r   <= stopped_nxt;
      fresh_r     <= fresh_nxt;
      pause_r     <= pause_nxt;
      savep_r     <= savep_nxt;
      since_dec_r <= since_dec_nxt;
      prev_a_r    <= enc_a;
      alarm_r     <= alarm_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/countdown_timer_click_encoder.sv
// Top level of the countdown timer: input register, button and time units,
// result register and the configuration register file. Depends on tce_pkg.
//
// Usage: each input word is one sample of the raw button line, the two encoder
// lines and a one-millisecond tick flag, sent on in_valid/in_ready. Every word
// gives exactly one result word on out_valid/out_ready with the displayed time,
// the running, paused and alarm flags and a tick pulse for the decrement.
// The word is held in the input register, then the button and time logic run
// in a single pass into the result register. Throughput is one word per cycle
// while the receiver takes the results; the input register is freed as soon
// as its word moves into the result register, so a new word is taken while a
// result waits. When the receiver stalls, the result register holds, the input
// register fills and in_ready drops after one more word.
// After reset the set and current time are 00:10, the timer is stopped, the
// alarm is clear and the registers hold their defaults. Configuration is
// written over the APB port; the user must write it only while the block is
// idle, the block itself does not enforce it. A write of the start minutes
// or seconds also loads the set and current time.
`default_nettype none

module countdown_timer_click_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_button_level,
  input  wire logic                        in_enc_a,
  input  wire logic                        in_enc_b,
  input  wire logic                        in_ms_tick,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tce_pkg::MIN_W-1:0]        out_minutes,
  output logic [tce_pkg::SEC_W-1:0]        out_seconds,
  output logic                             out_running,
  output logic                             out_paused,
  output logic                             out_alarm,
  output logic                             out_tick_pulse,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tce_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tce_pkg::DATA_W-1:0]  pwdata,
  output logic [tce_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import tce_pkg::*;

  logic   v1_r, v1_nxt;
  logic   btn_r, enc_a_r, enc_b_r, tick_r;
  logic   out_valid_r, out_valid_nxt;
  res_t   res_r, res_c;
  cfg_t   cfg_r;
  ld_t    ld;
  click_t click;
  logic   adv, wr;
  logic [2:0] idx;

  // The word moves on when the result register is empty or being drained.
  assign adv      = v1_r && (!out_valid_r || out_ready);
  assign in_ready = !v1_r || adv;

  always_comb begin
    v1_nxt        = (in_valid && in_ready) || (v1_r && !adv);
    out_valid_nxt = adv || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      btn_r   <= in_button_level;
      enc_a_r <= in_enc_a;
      enc_b_r <= in_enc_b;
      tick_r  <= in_ms_tick;
    end
    if (adv) begin
      res_r <= res_c;
    end
  end

  // Configuration register file.
  assign idx       = paddr[ADDR_W-1:2];
  assign wr        = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign ld.min_we = wr && (idx == REG_START_MIN);
  assign ld.sec_we = wr && (idx == REG_START_SEC);
  assign ld.value  = pwdata[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce  <= RST_DEBOUNCE;
      cfg_r.multi     <= RST_MULTI;
      cfg_r.start_min <= RST_START_MIN;
      cfg_r.start_sec <= RST_START_SEC;
      cfg_r.max_min   <= RST_MAX_MIN;
      cfg_r.period    <= RST_PERIOD;
    end else if (wr) begin
      case (idx)
        REG_DEBOUNCE:  cfg_r.debounce  <= pwdata[9:0];
        REG_MULTI:     cfg_r.multi     <= pwdata[10:0];
        REG_START_MIN: cfg_r.start_min <= pwdata[5:0];
        REG_START_SEC: cfg_r.start_sec <= pwdata[5:0];
        REG_MAX_MIN:   cfg_r.max_min   <= pwdata[MIN_W-1:0];
        REG_PERIOD:    cfg_r.period    <= pwdata[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE:  prdata = {22'd0, cfg_r.debounce};
      REG_MULTI:     prdata = {21'd0, cfg_r.multi};
      REG_START_MIN: prdata = {26'd0, cfg_r.start_min};
      REG_START_SEC: prdata = {26'd0, cfg_r.start_sec};
      REG_MAX_MIN:   prdata = {25'd0, cfg_r.max_min};
      REG_PERIOD:    prdata = {16'd0, cfg_r.period};
      default:       prdata = '0;
    endcase
  end

  tce_button u_button (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .button_level (btn_r),
    .ms_tick      (tick_r),
    .cfg          (cfg_r),
    .click        (click)
  );

  tce_time u_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .enc_a   (enc_a_r),
    .enc_b   (enc_b_r),
    .ms_tick (tick_r),
    .click   (click),
    .cfg     (cfg_r),
    .ld      (ld),
    .res     (res_c)
  );

  assign out_valid      = out_valid_r;
  assign out_minutes    = res_r.minutes;
  assign out_seconds    = res_r.seconds;
  assign out_running    = res_r.running;
  assign out_paused     = res_r.paused;
  assign out_alarm      = res_r.alarm;
  assign out_tick_pulse = res_r.tick_pulse;

  // A decrement only happens while counting down.
  a_tick_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tick_pulse |-> out_running)
    else $error("tick pulse while not running");

  // Pause is only entered from a running countdown, which it stops.
  a_paused_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_paused |-> !out_running)
    else $error("paused and running together");

  // Reaching 00:00 latches the alarm on the same word.
  a_zero_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_minutes == '0 && out_seconds == '0 |-> out_alarm)
    else $error("alarm not latched at 00:00");

  // A word taken into the result register leaves a valid result next cycle.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("result lost after advance");

endmodule

`default_nettype wire
